// ----- hdl/wbd_pkg.sv -----
// shared types, constants and the cordic arctangent table for the waypoint unit
package wbd_pkg;

  localparam int CNT_W     = 6;
  localparam int DIV_STEPS = 2;
  localparam int XW        = 36;
  localparam int ZW        = 33;
  localparam int MW        = 33;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 32;

  localparam logic [21:0]            DIV_K         = 22'd3515625;
  localparam logic [31:0]            DIV_M         = 32'd2562047788;
  localparam logic signed [MW-1:0]   K_Q30         = 33'sd652032874;
  localparam logic signed [MW-1:0]   DDEG_PER_TURN = 33'sd3600;
  localparam logic signed [MW-1:0]   DM_PER_TURN   = 33'sd400301736;
  localparam logic [11:0]            DDEG_WRAP     = 12'd3600;
  localparam logic [8:0]             GAIN_ONE      = 9'd256;
  localparam logic signed [ZW-1:0]   QUARTER_TURN  = 33'sd1073741824;
  localparam logic signed [ZW-1:0]   HALF_TURN     = 33'sd2147483648;
  localparam logic [31:0]            BAM_HALF      = 32'h8000_0000;
  localparam logic [31:0]            BAM_3QTR      = 32'hC000_0000;
  localparam logic [65:0]            RND_HALF      = 66'd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TGT_LAT = 3'd0,
    REG_TGT_LON = 3'd1,
    REG_RADIUS  = 3'd2,
    REG_AUTO    = 3'd3,
    REG_GAIN    = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_FILT, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_STORE,
    OP_ROT_INIT, OP_VEC_INIT, OP_CORDIC, OP_ROT_STORE, OP_VEC_STORE,
    OP_MUL, OP_MUL_STORE, OP_OUT
  } op_t;

  // operand selects
  localparam logic [3:0] DV_FLAT = 4'd0;
  localparam logic [3:0] DV_TLAT = 4'd1;
  localparam logic [3:0] DV_TLON = 4'd2;
  localparam logic [3:0] DV_FLON = 4'd3;
  localparam logic [3:0] RT_LATF = 4'd0;
  localparam logic [3:0] RT_LATT = 4'd1;
  localparam logic [3:0] RT_DLON = 4'd2;
  localparam logic [3:0] VC_BEAR = 4'd0;
  localparam logic [3:0] VC_DIST = 4'd1;
  localparam logic [3:0] MU_NUM  = 4'd0;
  localparam logic [3:0] MU_T6   = 4'd1;
  localparam logic [3:0] MU_DEN1 = 4'd2;
  localparam logic [3:0] MU_DEN2 = 4'd3;
  localparam logic [3:0] MU_CC1  = 4'd4;
  localparam logic [3:0] MU_CC2  = 4'd5;
  localparam logic [3:0] MU_HYP  = 4'd6;
  localparam logic [3:0] MU_BEAR = 4'd7;
  localparam logic [3:0] MU_DIST = 4'd8;

  typedef struct packed {
    op_t        op;
    logic [3:0] sel;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic signed [30:0] fix_lat;
    logic signed [31:0] fix_lon;
    logic               seed_filter;
  } in_t;

  typedef struct packed {
    logic [11:0] bearing_ddeg;
    logic [27:0] distance_dm;
    logic        reached;
    logic        advance;
  } out_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      5'd31: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/waypoint_bearing_distance.sv -----
// top level of the waypoint bearing and distance unit
//
//   port group   dir   handshake             carries
//   in_*         in    in_valid/in_ready     gps fix beat, wbd_pkg::in_t
//   out_*        out   out_valid/out_ready   bearing/distance beat, wbd_pkg::out_t
//   cfg_*        in    cfg_we                register write, index and data
//
// a fix passes through load, filter, four angle conversions, cordic passes and products, then output
// five cordic passes, three rotations and two vectorings, run on one shared unit
// the nine products run on one shared multiplier
// in_ready is high only while the sequencer is idle; one fix is in work at a time
// a finished result waits in the output register while the next fix is taken and worked on
// reset is synchronous and active low; it restores register defaults and clears the filter
module waypoint_bearing_distance #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  wbd_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output wbd_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [wbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [wbd_pkg::CFG_DW-1:0]     cfg_wdata
);
  import wbd_pkg::*;

  cmd_t cmd;

  wbd_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  wbd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .out_data (out_data)
  );

endmodule

// ----- hdl/wbd_ctrl.sv -----
// sequencer that steps the datapath through load, filter, conversions, cordic, products and output
module wbd_ctrl #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output wbd_pkg::cmd_t cmd
);
  import wbd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_FILT = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_ROT  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_VEC  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  localparam logic [CNT_W-1:0] CRD_END = CNT_W'(CORDIC_STEPS + 1);
  localparam logic [CNT_W-1:0] DIV_END = CNT_W'(DIV_STEPS + 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] cnt_m1;

  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.sel       = k_r;
    cmd.idx       = cnt_m1[4:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_FILT;
        end
      end
      S_FILT: begin
        cmd.op    = OP_FILT;
        state_nxt = S_DIV;
        cnt_nxt   = '0;
        k_nxt     = DV_FLAT;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == '0) begin
          cmd.op = OP_DIV_INIT;
        end else if (cnt_r == DIV_END) begin
          cmd.op  = OP_DIV_STORE;
          cnt_nxt = '0;
          if (k_r == DV_FLON) begin
            state_nxt = S_ROT;
            k_nxt     = RT_LATF;
          end else begin
            k_nxt = k_r + 4'd1;
          end
        end else begin
          cmd.op = OP_DIV_STEP;
        end
      end
      S_ROT: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == '0) begin
          cmd.op = OP_ROT_INIT;
        end else if (cnt_r == CRD_END) begin
          cmd.op  = OP_ROT_STORE;
          cnt_nxt = '0;
          if (k_r == RT_DLON) begin
            state_nxt = S_MUL;
            k_nxt     = MU_NUM;
          end else begin
            k_nxt = k_r + 4'd1;
          end
        end else begin
          cmd.op = OP_CORDIC;
        end
      end
      S_MUL: begin
        if (!cnt_r[0]) begin
          cmd.op  = OP_MUL;
          cnt_nxt = CNT_W'(1);
        end else begin
          cmd.op  = OP_MUL_STORE;
          cnt_nxt = '0;
          priority if (k_r == MU_CC2) begin
            state_nxt = S_VEC;
            k_nxt     = VC_BEAR;
          end else if (k_r == MU_HYP) begin
            state_nxt = S_VEC;
            k_nxt     = VC_DIST;
          end else if (k_r == MU_DIST) begin
            state_nxt = S_OUT;
          end else begin
            k_nxt = k_r + 4'd1;
          end
        end
      end
      S_VEC: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == '0) begin
          cmd.op = OP_VEC_INIT;
        end else if (cnt_r == CRD_END) begin
          cmd.op    = OP_VEC_STORE;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
          k_nxt     = (k_r == VC_BEAR) ? MU_HYP : MU_BEAR;
        end else begin
          cmd.op = OP_CORDIC;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hdl/wbd_dp.sv -----
// datapath: filter, angle conversion by reciprocal multiply, shared cordic, shared multiplier, result
module wbd_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wbd_pkg::cmd_t                  cmd,
  input  wbd_pkg::in_t                   in_data,
  input  logic                           cfg_we,
  input  logic [wbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [wbd_pkg::CFG_DW-1:0]     cfg_wdata,
  output wbd_pkg::out_t                  out_data
);
  import wbd_pkg::*;

  // configuration and filter state
  logic signed [30:0] tlat_r;
  logic signed [31:0] tlon_r;
  logic [19:0]        radius_r;
  logic               auto_r;
  logic [8:0]         gain_r;
  logic signed [31:0] filt_lat_r, filt_lon_r;

  // working registers
  logic signed [31:0] fix_lat_r, fix_lon_r;
  logic               seed_r;
  logic [63:0]        dprod_r;
  logic               dlsb_r;
  logic [22:0]        rem_r;
  logic [31:0]        dsh_r;
  logic               dneg_r;
  logic [31:0]        laf_r, lat_r, tlonb_r, dl_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic               rot_r, flip_r, vz_r;
  logic signed [XW-1:0] s1_r, c1_r, s2_r, c2_r, sd_r, cd_r;
  logic signed [XW-1:0] num_r, t6_r, den_r, cc_r, hyp_r, mag_r;
  logic [31:0]        angb_r, angd_r;
  logic signed [2*MW-1:0] prod_r;
  logic [11:0]        bear_r;
  logic [27:0]        dist_r;
  out_t               out_r;

  // filter
  logic [8:0]         gain_sat;
  logic signed [32:0] dlat, dlon;
  logic signed [42:0] fp_lat, fp_lon, fs_lat, fs_lon;

  assign gain_sat = (gain_r > GAIN_ONE) ? GAIN_ONE : gain_r;
  assign dlat     = {fix_lat_r[31], fix_lat_r} - {filt_lat_r[31], filt_lat_r};
  assign dlon     = {fix_lon_r[31], fix_lon_r} - {filt_lon_r[31], filt_lon_r};
  assign fp_lat   = dlat * $signed({1'b0, gain_sat});
  assign fp_lon   = dlon * $signed({1'b0, gain_sat});
  assign fs_lat   = fp_lat >>> 8;
  assign fs_lon   = fp_lon >>> 8;

  // degrees*1e7 to binary angle: reciprocal estimate, then one remainder correction
  logic signed [31:0] dsrc;
  logic [31:0]        dmag, dq;
  logic [44:0]        dqk;

  always_comb begin
    unique case (cmd.sel[1:0])
      2'd0:    dsrc = filt_lat_r;
      2'd1:    dsrc = {tlat_r[30], tlat_r};
      2'd2:    dsrc = tlon_r;
      default: dsrc = filt_lon_r;
    endcase
  end

  assign dmag = dsrc[31] ? (32'd0 - dsrc) : dsrc;
  assign dqk  = dprod_r[53:31] * DIV_K;
  assign dq   = dneg_r ? (32'd0 - dsh_r) : dsh_r;

  // cordic setup and step
  logic [31:0]          rang;
  logic signed [ZW-1:0] rz0, rz1;
  logic                 rflip;
  logic signed [XW-1:0] vx, vy, cdx, cdy, sv, cv;
  logic signed [ZW-1:0] catan;
  logic                 cdec;

  always_comb begin
    unique case (cmd.sel)
      RT_LATF: rang = laf_r;
      RT_LATT: rang = lat_r;
      default: rang = dl_r;
    endcase
    rz0   = $signed({rang[31], rang});
    rflip = 1'b0;
    rz1   = rz0;
    if (rz0 > QUARTER_TURN) begin
      rz1   = rz0 - HALF_TURN;
      rflip = 1'b1;
    end else if (rz0 < -QUARTER_TURN) begin
      rz1   = rz0 + HALF_TURN;
      rflip = 1'b1;
    end
  end

  always_comb begin
    if (cmd.sel == VC_BEAR) begin
      vx = den_r;
      vy = num_r;
    end else begin
      vx = cc_r;
      vy = hyp_r;
    end
  end

  assign cdx   = y_r >>> cmd.idx;
  assign cdy   = x_r >>> cmd.idx;
  assign catan = $signed({1'b0, atan_bam(cmd.idx)});
  assign cdec  = rot_r ? !z_r[ZW-1] : y_r[XW-1];
  assign sv    = flip_r ? -y_r : y_r;
  assign cv    = flip_r ? -x_r : x_r;

  // shared multiplier
  logic signed [MW-1:0] ma, mb;
  logic [31:0]          angd_c;
  logic signed [XW-1:0] qv;
  logic [65:0]          prnd;

  always_comb begin
    if (angd_r > BAM_3QTR) angd_c = '0;
    else if (angd_r > BAM_HALF) angd_c = BAM_HALF;
    else angd_c = angd_r;
  end

  always_comb begin
    unique case (cmd.sel)
      MU_NUM:  begin ma = c2_r[MW-1:0]; mb = sd_r[MW-1:0]; end
      MU_T6:   begin ma = c2_r[MW-1:0]; mb = cd_r[MW-1:0]; end
      MU_DEN1: begin ma = c1_r[MW-1:0]; mb = s2_r[MW-1:0]; end
      MU_DEN2: begin ma = s1_r[MW-1:0]; mb = t6_r[MW-1:0]; end
      MU_CC1:  begin ma = s1_r[MW-1:0]; mb = s2_r[MW-1:0]; end
      MU_CC2:  begin ma = c1_r[MW-1:0]; mb = t6_r[MW-1:0]; end
      MU_HYP:  begin ma = mag_r[MW-1:0]; mb = K_Q30; end
      MU_BEAR: begin ma = $signed({1'b0, angb_r}); mb = DDEG_PER_TURN; end
      MU_DIST: begin ma = $signed({1'b0, angd_c}); mb = DM_PER_TURN; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign qv   = prod_r[2*MW-1:30];
  assign prnd = prod_r + RND_HALF;

  // result
  logic        coin;
  logic [27:0] dist_o;
  out_t        res;

  assign coin   = (laf_r == lat_r) && (dl_r == '0);
  assign dist_o = coin ? '0 : dist_r;

  always_comb begin
    res.bearing_ddeg = coin ? '0 : bear_r;
    res.distance_dm  = dist_o;
    res.reached      = (dist_o < {8'd0, radius_r});
    res.advance      = res.reached & auto_r;
  end

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlat_r     <= '0;
      tlon_r     <= '0;
      radius_r   <= '0;
      auto_r     <= 1'b0;
      gain_r     <= 9'd128;
      filt_lat_r <= '0;
      filt_lon_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_TGT_LAT: tlat_r   <= cfg_wdata[30:0];
          REG_TGT_LON: tlon_r   <= cfg_wdata[31:0];
          REG_RADIUS:  radius_r <= cfg_wdata[19:0];
          REG_AUTO:    auto_r   <= cfg_wdata[0];
          REG_GAIN:    gain_r   <= cfg_wdata[8:0];
          default:     ;
        endcase
      end
      if (cmd.op == OP_FILT) begin
        if (seed_r) begin
          filt_lat_r <= fix_lat_r;
          filt_lon_r <= fix_lon_r;
        end else begin
          filt_lat_r <= filt_lat_r + fs_lat[31:0];
          filt_lon_r <= filt_lon_r + fs_lon[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        fix_lat_r <= {in_data.fix_lat[30], in_data.fix_lat};
        fix_lon_r <= in_data.fix_lon;
        seed_r    <= in_data.seed_filter;
      end
      OP_DIV_INIT: begin
        dprod_r <= dmag * DIV_M;
        dlsb_r  <= dmag[0];
        dneg_r  <= dsrc[31];
      end
      OP_DIV_STEP: begin
        if (cmd.idx == '0) begin
          dsh_r <= dprod_r[62:31];
          rem_r <= {dlsb_r, 22'd0} - dqk[22:0];
        end else if (rem_r >= {1'b0, DIV_K}) begin
          dsh_r <= dsh_r + 32'd1;
        end
      end
      OP_DIV_STORE: begin
        unique case (cmd.sel)
          DV_FLAT: laf_r   <= dq;
          DV_TLAT: lat_r   <= dq;
          DV_TLON: tlonb_r <= dq;
          default: dl_r    <= tlonb_r - dq;
        endcase
      end
      OP_ROT_INIT: begin
        x_r    <= XW'(K_Q30);
        y_r    <= '0;
        z_r    <= rz1;
        flip_r <= rflip;
        rot_r  <= 1'b1;
      end
      OP_VEC_INIT: begin
        rot_r <= 1'b0;
        vz_r  <= (vx == '0) && (vy == '0);
        if (vx[XW-1]) begin
          x_r <= -vx;
          y_r <= -vy;
          z_r <= HALF_TURN;
        end else begin
          x_r <= vx;
          y_r <= vy;
          z_r <= '0;
        end
      end
      OP_CORDIC: begin
        if (cdec) begin
          x_r <= x_r - cdx;
          y_r <= y_r + cdy;
          z_r <= z_r - catan;
        end else begin
          x_r <= x_r + cdx;
          y_r <= y_r - cdy;
          z_r <= z_r + catan;
        end
      end
      OP_ROT_STORE: begin
        unique case (cmd.sel)
          RT_LATF: begin s1_r <= sv; c1_r <= cv; end
          RT_LATT: begin s2_r <= sv; c2_r <= cv; end
          default: begin sd_r <= sv; cd_r <= cv; end
        endcase
      end
      OP_VEC_STORE: begin
        if (cmd.sel == VC_BEAR) begin
          angb_r <= vz_r ? '0 : z_r[31:0];
          mag_r  <= vz_r ? '0 : x_r;
        end else begin
          angd_r <= vz_r ? '0 : z_r[31:0];
        end
      end
      OP_MUL: prod_r <= ma * mb;
      OP_MUL_STORE: begin
        unique case (cmd.sel)
          MU_NUM:  num_r <= qv;
          MU_T6:   t6_r  <= qv;
          MU_DEN1: den_r <= qv;
          MU_DEN2: den_r <= den_r - qv;
          MU_CC1:  cc_r  <= qv;
          MU_CC2:  cc_r  <= cc_r + qv;
          MU_HYP:  hyp_r <= qv;
          MU_BEAR: bear_r <= (prnd[43:32] >= DDEG_WRAP) ? '0 : prnd[43:32];
          default: dist_r <= prnd[59:32];
        endcase
      end
      OP_OUT: out_r <= res;
      default: ;
    endcase
  end

endmodule

// ----- hdl/wbd_chk.sv -----
// port checker for the waypoint unit and its bind
module wbd_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input wbd_pkg::out_t out_data
);
  import wbd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second fix taken while one is in work");

  a_advance_reached: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.advance || out_data.reached))
    else $error("advance without reached");

  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.bearing_ddeg < DDEG_WRAP))
    else $error("bearing out of range");

endmodule

bind waypoint_bearing_distance wbd_chk u_wbd_chk (.*);
